### hdl/palette_error_diffusion_dither_unit_assert.svh
// Assertion macros for the dither unit.
`ifndef PALETTE_ERROR_DIFFUSION_DITHER_UNIT_ASSERT_SVH
`define PALETTE_ERROR_DIFFUSION_DITHER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define PEDD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define PEDD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PEDD_ASSERT(lbl, clk, rstn, prop, msg)
`define PEDD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### hdl/pedd_pkg.sv
`default_nettype none

package pedd_pkg;

    localparam int MAX_WIDTH_DEF    = 1024;
    localparam int MAX_HEIGHT_DEF   = 4096;
    localparam int PALETTE_SIZE_DEF = 64;

    localparam logic [10:0] IMAGE_WIDTH_RST  = 11'd640;
    localparam logic [12:0] IMAGE_HEIGHT_RST = 13'd480;

    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 16;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 13;

    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 8'd1;

    localparam logic [3:0] W_RIGHT      = 4'd7;
    localparam logic [3:0] W_DOWN_LEFT  = 4'd3;
    localparam logic [3:0] W_DOWN       = 4'd5;
    localparam logic [3:0] W_DOWN_RIGHT = 4'd1;

    typedef logic signed [8:0] err9_t;

    typedef struct packed {
        err9_t r;
        err9_t g;
        err9_t b;
    } err_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_ADD  = 7'b0000010,
        S_SRCH = 7'b0000100,
        S_ERR  = 7'b0001000,
        S_UPD  = 7'b0010000,
        S_TAIL = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

endpackage

`default_nettype wire

### hdl/palette_error_diffusion_dither_unit.sv
// Error-diffusion dither onto a palette of PALETTE_SIZE colors. A beat with s_tuser high
// writes one palette entry; a beat with s_tuser low is a pixel in raster order and yields
// one result beat with the nearest entry's index and packed code, tlast on the last pixel
// of a row and tuser on the last pixel of the frame. Pixels are taken only while idle, so
// a new pixel waits until the last one's result is registered for output, and meanwhile
// the search reads the palette memory one entry per cycle through a two-stage distance
// pipeline. Row errors live in one memory of MAX_WIDTH entries, overwritten as the row is
// swept; the first row of a frame reads them as zero, so no clearing pass is run. Write the
// whole palette before the first pixel. A write to image_width or image_height restarts the
// frame.
`default_nettype none
`include "palette_error_diffusion_dither_unit_assert.svh"

module palette_error_diffusion_dither_unit #(
    parameter int MAX_WIDTH    = pedd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT   = pedd_pkg::MAX_HEIGHT_DEF,
    parameter int PALETTE_SIZE = pedd_pkg::PALETTE_SIZE_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // entry_index[5:0], red[13:6], green[21:14], blue[29:22], zero[31:30]
    input  wire logic [pedd_pkg::S_TDATA_W-1:0]   s_tdata,
    // kind[0]
    input  wire logic [0:0]                       s_tuser,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // palette_index[5:0], packed_code[11:6], zero[15:12]
    output logic [pedd_pkg::M_TDATA_W-1:0]        m_tdata,
    // frame_end[0]
    output logic [0:0]                            m_tuser,
    output logic                                  m_tlast,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [pedd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [pedd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import pedd_pkg::*;

    localparam int XW     = $clog2(MAX_WIDTH);
    localparam int CW     = XW + 1;
    localparam int HCNT_W = $clog2(MAX_HEIGHT + 1);
    localparam int HW1    = HCNT_W + 1;
    localparam int PIDX_W = $clog2(PALETTE_SIZE);
    localparam int PCNT_W = $clog2(PALETTE_SIZE + 1);

    function automatic err9_t share1(err9_t e, logic [3:0] w);
        logic signed [13:0] prod;
        logic signed [13:0] biased;
        prod   = 14'(e) * 14'($signed({1'b0, w}));
        biased = prod + ((prod < 0) ? 14'sd15 : 14'sd0);
        return err9_t'(biased >>> 4);
    endfunction

    function automatic err_t share(err_t e, logic [3:0] w);
        err_t s;
        s.r = share1(e.r, w);
        s.g = share1(e.g, w);
        s.b = share1(e.b, w);
        return s;
    endfunction

    function automatic err_t err_add(err_t a, err_t b);
        err_t s;
        s.r = a.r + b.r;
        s.g = a.g + b.g;
        s.b = a.b + b.b;
        return s;
    endfunction

    function automatic logic [7:0] add_clamp(logic [7:0] p, err9_t c, err9_t rw);
        logic signed [10:0] s;
        s = $signed({3'b000, p}) + 11'(c) + 11'(rw);
        if (s < 0) begin
            return 8'd0;
        end else if (s > 11'sd255) begin
            return 8'd255;
        end
        return s[7:0];
    endfunction

    function automatic logic [15:0] sqdiff(logic [7:0] a, logic [7:0] b);
        logic [7:0] d;
        d = (a >= b) ? (a - b) : (b - a);
        return d * d;
    endfunction

    function automatic err9_t diff9(logic [7:0] a, logic [7:0] b);
        return $signed({1'b0, a}) - $signed({1'b0, b});
    endfunction

    state_t state_reg, state_next;
    logic [XW-1:0] col_reg, col_next;
    logic [HCNT_W-1:0] row_reg, row_next;
    logic first_row_reg, first_row_next;
    logic [10:0] img_w_reg, img_w_next;
    logic [12:0] img_h_reg, img_h_next;
    err_t carry_reg, carry_next;
    err_t acc_l_reg, acc_l_next;
    err_t acc_c_reg, acc_c_next;
    logic [PCNT_W-1:0] rd_cnt_reg, rd_cnt_next;
    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic m_tvalid_reg, m_tvalid_next;

    rgb_t pix_reg, pix_next;
    rgb_t corr_reg, corr_next;
    logic [PIDX_W-1:0] idx1_reg, idx1_next;
    logic [PIDX_W-1:0] idx2_reg, idx2_next;
    rgb_t ent2_reg, ent2_next;
    logic [15:0] sq_r_reg, sq_r_next;
    logic [15:0] sq_g_reg, sq_g_next;
    logic [15:0] sq_b_reg, sq_b_next;
    logic [17:0] best_d_reg, best_d_next;
    logic [PIDX_W-1:0] best_idx_reg, best_idx_next;
    rgb_t best_ent_reg, best_ent_next;
    err_t e_reg, e_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic m_tlast_reg, m_tlast_next;
    logic m_tuser_reg, m_tuser_next;

    rgb_t pal_mem [PALETTE_SIZE];
    rgb_t pal_rdata_reg;
    err_t row_mem [MAX_WIDTH];
    err_t row_rdata_reg;

    logic s_accept;
    logic pix_accept;
    logic pal_we;
    rgb_t s_rgb;
    logic [CW-1:0] width_eff;
    logic [HCNT_W-1:0] height_eff;
    logic last_col;
    logic last_row;
    logic issue;
    logic [PIDX_W-1:0] rd_addr;
    logic [17:0] dsum;
    err_t row_err;
    err_t s7, s3, s5, s1;
    logic row_we;
    logic [XW-1:0] row_waddr;
    err_t row_wdata;
    logic out_free;
    logic restart;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign s_accept  = s_tvalid & s_tready;
    assign pix_accept = s_accept & ~s_tuser[0];
    assign pal_we    = s_accept & s_tuser[0] & (32'(s_tdata[5:0]) < 32'(PALETTE_SIZE));
    assign s_rgb.r   = s_tdata[13:6];
    assign s_rgb.g   = s_tdata[21:14];
    assign s_rgb.b   = s_tdata[29:22];

    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tvalid = m_tvalid_reg;
    assign out_free = ~m_tvalid_reg | m_tready;

    always_comb begin
        if (img_w_reg == '0) begin
            width_eff = CW'(1);
        end else if (32'(img_w_reg) > 32'(MAX_WIDTH)) begin
            width_eff = CW'(MAX_WIDTH);
        end else begin
            width_eff = CW'(img_w_reg);
        end
        if (img_h_reg == '0) begin
            height_eff = HCNT_W'(1);
        end else if (32'(img_h_reg) > 32'(MAX_HEIGHT)) begin
            height_eff = HCNT_W'(MAX_HEIGHT);
        end else begin
            height_eff = HCNT_W'(img_h_reg);
        end
    end

    assign last_col = (CW'(col_reg) + CW'(1)) >= width_eff;
    assign last_row = (HW1'(row_reg) + HW1'(1)) >= HW1'(height_eff);
    assign issue    = (state_reg == S_SRCH) && (rd_cnt_reg < PCNT_W'(PALETTE_SIZE));
    assign rd_addr  = rd_cnt_reg[PIDX_W-1:0];
    assign dsum     = 18'(sq_r_reg) + 18'(sq_g_reg) + 18'(sq_b_reg);
    assign row_err  = first_row_reg ? err_t'('0) : row_rdata_reg;
    assign s7       = share(e_reg, W_RIGHT);
    assign s3       = share(e_reg, W_DOWN_LEFT);
    assign s5       = share(e_reg, W_DOWN);
    assign s1       = share(e_reg, W_DOWN_RIGHT);

    always_comb begin
        state_next     = state_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        first_row_next = first_row_reg;
        img_w_next     = img_w_reg;
        img_h_next     = img_h_reg;
        carry_next     = carry_reg;
        acc_l_next     = acc_l_reg;
        acc_c_next     = acc_c_reg;
        rd_cnt_next    = rd_cnt_reg;
        m_tvalid_next  = m_tvalid_reg & ~m_tready;
        pix_next       = pix_reg;
        corr_next      = corr_reg;
        e_next         = e_reg;
        m_tdata_next   = m_tdata_reg;
        m_tlast_next   = m_tlast_reg;
        m_tuser_next   = m_tuser_reg;
        row_we         = 1'b0;
        row_waddr      = col_reg - XW'(1);
        row_wdata      = err_add(acc_l_reg, s3);
        restart        = 1'b0;

        // distance pipeline: read, square, compare
        v1_next        = issue;
        idx1_next      = rd_addr;
        v2_next        = v1_reg;
        idx2_next      = idx1_reg;
        ent2_next      = pal_rdata_reg;
        sq_r_next      = sqdiff(corr_reg.r, pal_rdata_reg.r);
        sq_g_next      = sqdiff(corr_reg.g, pal_rdata_reg.g);
        sq_b_next      = sqdiff(corr_reg.b, pal_rdata_reg.b);
        best_d_next    = best_d_reg;
        best_idx_next  = best_idx_reg;
        best_ent_next  = best_ent_reg;
        if (v2_reg && ((idx2_reg == '0) || (dsum < best_d_reg))) begin
            best_d_next   = dsum;
            best_idx_next = idx2_reg;
            best_ent_next = ent2_reg;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (pix_accept) begin
                    pix_next   = s_rgb;
                    state_next = S_ADD;
                end
            end
            S_ADD: begin
                corr_next.r = add_clamp(pix_reg.r, carry_reg.r, row_err.r);
                corr_next.g = add_clamp(pix_reg.g, carry_reg.g, row_err.g);
                corr_next.b = add_clamp(pix_reg.b, carry_reg.b, row_err.b);
                rd_cnt_next = '0;
                state_next  = S_SRCH;
            end
            S_SRCH: begin
                if (issue) begin
                    rd_cnt_next = rd_cnt_reg + PCNT_W'(1);
                end else if (!v1_reg && !v2_reg) begin
                    state_next = S_ERR;
                end
            end
            S_ERR: begin
                e_next.r   = diff9(corr_reg.r, best_ent_reg.r);
                e_next.g   = diff9(corr_reg.g, best_ent_reg.g);
                e_next.b   = diff9(corr_reg.b, best_ent_reg.b);
                state_next = S_UPD;
            end
            S_UPD: begin
                // retire the entry below-left, shift the window right
                row_we     = (col_reg != '0);
                acc_l_next = err_add(acc_c_reg, s5);
                acc_c_next = last_col ? err_t'('0) : s1;
                carry_next = last_col ? err_t'('0) : s7;
                state_next = last_col ? S_TAIL : S_OUT;
            end
            S_TAIL: begin
                row_we     = 1'b1;
                row_waddr  = col_reg;
                row_wdata  = acc_l_reg;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'b0000, best_ent_reg.r[5:4], best_ent_reg.g[3:2],
                                     best_ent_reg.b[1:0], 6'(best_idx_reg)};
                    m_tlast_next  = last_col;
                    m_tuser_next  = last_col & last_row;
                    state_next    = S_IDLE;
                    if (last_col && last_row) begin
                        restart = 1'b1;
                    end else if (last_col) begin
                        col_next       = '0;
                        row_next       = row_reg + HCNT_W'(1);
                        first_row_next = 1'b0;
                        acc_l_next     = '0;
                        acc_c_next     = '0;
                    end else begin
                        col_next = col_reg + XW'(1);
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH: begin
                    img_w_next = cfg_data[10:0];
                    restart    = 1'b1;
                end
                CFG_IMAGE_HEIGHT: begin
                    img_h_next = cfg_data[12:0];
                    restart    = 1'b1;
                end
                default: begin
                end
            endcase
        end

        if (restart) begin
            col_next       = '0;
            row_next       = '0;
            first_row_next = 1'b1;
            carry_next     = '0;
            acc_l_next     = '0;
            acc_c_next     = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            first_row_reg <= 1'b1;
            img_w_reg     <= IMAGE_WIDTH_RST;
            img_h_reg     <= IMAGE_HEIGHT_RST;
            carry_reg     <= '0;
            acc_l_reg     <= '0;
            acc_c_reg     <= '0;
            rd_cnt_reg    <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            first_row_reg <= first_row_next;
            img_w_reg     <= img_w_next;
            img_h_reg     <= img_h_next;
            carry_reg     <= carry_next;
            acc_l_reg     <= acc_l_next;
            acc_c_reg     <= acc_c_next;
            rd_cnt_reg    <= rd_cnt_next;
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pix_reg      <= pix_next;
        corr_reg     <= corr_next;
        idx1_reg     <= idx1_next;
        idx2_reg     <= idx2_next;
        ent2_reg     <= ent2_next;
        sq_r_reg     <= sq_r_next;
        sq_g_reg     <= sq_g_next;
        sq_b_reg     <= sq_b_next;
        best_d_reg   <= best_d_next;
        best_idx_reg <= best_idx_next;
        best_ent_reg <= best_ent_next;
        e_reg        <= e_next;
        m_tdata_reg  <= m_tdata_next;
        m_tlast_reg  <= m_tlast_next;
        m_tuser_reg  <= m_tuser_next;
    end

    always_ff @(posedge aclk) begin
        if (pal_we) begin
            pal_mem[PIDX_W'(s_tdata[5:0])] <= s_rgb;
        end
        if (issue) begin
            pal_rdata_reg <= pal_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (row_we) begin
            row_mem[row_waddr] <= row_wdata;
        end
        if (pix_accept) begin
            row_rdata_reg <= row_mem[col_reg];
        end
    end

    `PEDD_ASSERT(a_search_full, aclk, aresetn, (state_reg == S_ERR) |-> (rd_cnt_reg == PCNT_W'(PALETTE_SIZE)), "palette search ended early")
    `PEDD_ASSERT(a_tail_last_col, aclk, aresetn, (state_reg == S_TAIL) |-> last_col, "tail write off the row end")
    `PEDD_ASSERT(a_col_in_range, aclk, aresetn, (CW'(col_reg) < width_eff), "column beyond image width")
    `PEDD_ASSERT(a_out_from_out, aclk, aresetn, $rose(m_tvalid_reg) |-> $past(state_reg == S_OUT), "result beat without finished pixel")
    `PEDD_ASSERT_ALWAYS(a_reset_out, aclk, !aresetn |=> !m_tvalid_reg, "result valid after reset")

endmodule

`default_nettype wire
